// File: hw/rtl/gtp_pkg.sv
// Shared types, constants and the alphabet reverse lookup for the
// GSM 7-bit text encoder and septet packer. No dependencies.
package gtp_pkg;

	localparam int TABLE_SIZE = 128;
	localparam logic [6:0] UNKNOWN_SEPTET = 7'h3F;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam logic [15:0] GSM_TABLE [TABLE_SIZE] = '{
		16'h0040, 16'h00A3, 16'h0024, 16'h00A5, 16'h00E8, 16'h00E9, 16'h00F9, 16'h00EC,
		16'h00F2, 16'h00C7, 16'h000A, 16'h00D8, 16'h00F8, 16'h000D, 16'h00C5, 16'h00E5,
		16'h0394, 16'h005F, 16'h03A6, 16'h0393, 16'h039B, 16'h03A9, 16'h03A0, 16'h03A8,
		16'h03A3, 16'h0398, 16'h039E, 16'h0000, 16'h00C6, 16'h00E6, 16'h00DF, 16'h00C9,
		16'h0020, 16'h0021, 16'h0022, 16'h0023, 16'h00A4, 16'h0025, 16'h0026, 16'h0027,
		16'h0028, 16'h0029, 16'h002A, 16'h002B, 16'h002C, 16'h002D, 16'h002E, 16'h002F,
		16'h0030, 16'h0031, 16'h0032, 16'h0033, 16'h0034, 16'h0035, 16'h0036, 16'h0037,
		16'h0038, 16'h0039, 16'h003A, 16'h003B, 16'h003C, 16'h003D, 16'h003E, 16'h003F,
		16'h00A1, 16'h0041, 16'h0042, 16'h0043, 16'h0044, 16'h0045, 16'h0046, 16'h0047,
		16'h0048, 16'h0049, 16'h004A, 16'h004B, 16'h004C, 16'h004D, 16'h004E, 16'h004F,
		16'h0050, 16'h0051, 16'h0052, 16'h0053, 16'h0054, 16'h0055, 16'h0056, 16'h0057,
		16'h0058, 16'h0059, 16'h005A, 16'h00C4, 16'h00D6, 16'h00D1, 16'h00DC, 16'h00A7,
		16'h00BF, 16'h0061, 16'h0062, 16'h0063, 16'h0064, 16'h0065, 16'h0066, 16'h0067,
		16'h0068, 16'h0069, 16'h006A, 16'h006B, 16'h006C, 16'h006D, 16'h006E, 16'h006F,
		16'h0070, 16'h0071, 16'h0072, 16'h0073, 16'h0074, 16'h0075, 16'h0076, 16'h0077,
		16'h0078, 16'h0079, 16'h007A, 16'h00E4, 16'h00F6, 16'h00F1, 16'h00FC, 16'h00E0
	};

	// One classified character waiting for the packer.
	typedef struct packed {
		logic [6:0] septet;
		logic       last;
	} item_t;

	// Higher index wins on a duplicate code.
	function automatic logic [6:0] septet_of(input logic [15:0] code);
		logic [6:0] idx;
		idx = UNKNOWN_SEPTET;
		for (int i = 0; i < TABLE_SIZE; i++) begin
			if (GSM_TABLE[i] == code) begin
				idx = 7'(i);
			end
		end
		return idx;
	endfunction

endpackage

// File: hw/rtl/gtp_char_if.sv
// Character channel: valid/ready handshake with one character code per transfer.
// No dependencies.
interface gtp_char_if;
	logic        valid;
	logic        ready;
	logic [15:0] char_code;
	logic        end_of_text;

	modport source (output valid, output char_code, output end_of_text, input ready);
	modport sink (input valid, input char_code, input end_of_text, output ready);
endinterface

// File: hw/rtl/gtp_octet_if.sv
// Octet channel: valid/ready handshake with one packed octet per transfer.
// No dependencies.
interface gtp_octet_if;
	logic       valid;
	logic       ready;
	logic [7:0] packed_octet;
	logic       final_octet;

	modport source (output valid, output packed_octet, output final_octet, input ready);
	modport sink (input valid, input packed_octet, input final_octet, output ready);
endinterface

// File: hw/rtl/gtp_front.sv
// Front stage: accepts characters and maps each code to its septet index.
// Depends on gtp_pkg and gtp_char_if.
module gtp_front (
	input  logic           clk,
	input  logic           arst_n,
	gtp_char_if.sink       chars,
	output gtp_pkg::item_t push_item,
	output logic           push,
	input  logic           full
);

	logic           vld_s1;
	gtp_pkg::item_t item_s1;

	assign push      = vld_s1 && !full;
	assign push_item = item_s1;
	assign chars.ready = !vld_s1 || !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (chars.ready) begin
			vld_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			item_s1.septet <= gtp_pkg::septet_of(chars.char_code);
			item_s1.last   <= chars.end_of_text;
		end
	end

endmodule

// File: hw/rtl/gtp_fifo.sv
// Short queue of classified characters between the front stage and the packer.
// Depends on gtp_pkg.
module gtp_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  gtp_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output gtp_pkg::item_t head,
	output logic           empty
);

	gtp_pkg::item_t                  slot_q [gtp_pkg::FIFO_DEPTH];
	logic [gtp_pkg::FIFO_PTR_W-1:0] wr_q;
	logic [gtp_pkg::FIFO_PTR_W-1:0] rd_q;
	logic [gtp_pkg::FIFO_CNT_W-1:0] count_q;
	logic                            do_push;
	logic                            do_pop;

	assign full    = count_q == gtp_pkg::FIFO_CNT_W'(gtp_pkg::FIFO_DEPTH);
	assign empty   = count_q == '0;
	assign head    = slot_q[rd_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	function automatic logic [gtp_pkg::FIFO_PTR_W-1:0] next_ptr(
		input logic [gtp_pkg::FIFO_PTR_W-1:0] p
	);
		logic [gtp_pkg::FIFO_PTR_W-1:0] n;
		n = (p == gtp_pkg::FIFO_PTR_W'(gtp_pkg::FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
		return n;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= next_ptr(wr_q);
			end
			if (do_pop) begin
				rd_q <= next_ptr(rd_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push_item;
		end
	end

	// Occupancy never exceeds the depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= gtp_pkg::FIFO_CNT_W'(gtp_pkg::FIFO_DEPTH))
		else $error("queue occupancy out of range");

endmodule

// File: hw/rtl/gtp_pack.sv
// Back stage: packs septets into octets, inserts filler at message start and
// flushes on the last character. Depends on gtp_pkg and gtp_octet_if.
module gtp_pack (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [2:0]     filler,
	input  gtp_pkg::item_t head,
	input  logic           empty,
	output logic           pop,
	gtp_octet_if.source    octets
);

	logic [6:0] bits_q;
	logic [2:0] cnt_q;
	logic       in_msg_q;
	logic       oct_vld_q;
	logic [7:0] oct_q;
	logic       fin_q;
	logic       second_q;
	logic [6:0] sec_q;

	logic [6:0]  p_bits;
	logic [2:0]  p_cnt;
	logic [13:0] acc;
	logic [3:0]  cnt4;
	logic        full_oct;
	logic [6:0]  rem;
	logic [2:0]  rem_cnt;
	logic        emit;
	logic        two;
	logic        fin_first;
	logic        slot_free;

	always_comb begin
		p_bits    = in_msg_q ? bits_q : 7'd0;
		p_cnt     = in_msg_q ? cnt_q : filler;
		acc       = {7'd0, p_bits} | ({7'd0, head.septet} << p_cnt);
		cnt4      = {1'b0, p_cnt} + 4'd7;
		full_oct  = cnt4[3];
		rem       = full_oct ? {1'b0, acc[13:8]} : acc[6:0];
		rem_cnt   = full_oct ? cnt4[2:0] : 3'd7;
		emit      = full_oct || head.last;
		two       = full_oct && head.last && (rem_cnt != 3'd0);
		fin_first = head.last && !two;
	end

	assign slot_free = !oct_vld_q || octets.ready;
	// Hold the queue while a second octet still waits its turn.
	assign pop = !empty && !second_q && (slot_free || !emit);

	assign octets.valid        = oct_vld_q;
	assign octets.packed_octet = oct_q;
	assign octets.final_octet  = fin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q    <= '0;
			cnt_q     <= '0;
			in_msg_q  <= 1'b0;
			oct_vld_q <= 1'b0;
			second_q  <= 1'b0;
		end else begin
			if (pop) begin
				if (head.last) begin
					bits_q   <= '0;
					cnt_q    <= '0;
					in_msg_q <= 1'b0;
				end else begin
					bits_q   <= rem;
					cnt_q    <= rem_cnt;
					in_msg_q <= 1'b1;
				end
			end
			if (second_q && slot_free) begin
				oct_vld_q <= 1'b1;
				second_q  <= 1'b0;
			end else if (pop && emit) begin
				oct_vld_q <= 1'b1;
				second_q  <= two;
			end else if (octets.ready) begin
				oct_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (second_q && slot_free) begin
			oct_q <= {1'b0, sec_q};
			fin_q <= 1'b1;
		end else if (pop && emit) begin
			oct_q <= acc[7:0];
			fin_q <= fin_first;
			sec_q <= rem;
		end
	end

	a_second_shown: assert property (@(posedge clk) disable iff (!arst_n)
		second_q |-> oct_vld_q)
		else $error("second octet pending without a shown octet");

	a_two_then_second: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && two) |=> (second_q && !fin_q))
		else $error("split octet pair not staged");

	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head.last) |=> (!in_msg_q && cnt_q == 3'd0))
		else $error("message state not cleared after last character");

endmodule

// File: hw/rtl/gsm7_text_encode_pack.sv
// Top level of the GSM 7-bit text encoder and septet packer.
// Depends on gtp_pkg, gtp_char_if, gtp_octet_if, gtp_front, gtp_fifo, gtp_pack.
//
// Takes one 16-bit character per transfer, maps it to its default-alphabet
// septet (unknown codes give '?') and packs septets LSB first into octets,
// with filler_bits zero bits ahead of each message's first septet; the
// filler value is sampled when a message's first character reaches the
// packer. A character is taken every cycle while the queue is not full;
// a character yields zero, one, or two octets (two only on a last
// character that overflows), so the octet port at one transfer per cycle,
// while its sink is ready, sets the sustained rate. Each character passes
// the lookup register, four-entry queue and output register on its way out.
module gsm7_text_encode_pack (
	input  logic       clk,
	input  logic       arst_n,
	gtp_char_if.sink   chars,
	gtp_octet_if.source octets,
	input  logic       filler_we,
	input  logic [2:0] filler_bits
);

	logic [2:0]     filler_q;
	gtp_pkg::item_t push_item;
	gtp_pkg::item_t head;
	logic           push;
	logic           full;
	logic           pop;
	logic           empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filler_q <= '0;
		end else if (filler_we) begin
			filler_q <= filler_bits;
		end
	end

	gtp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.chars     (chars),
		.push_item (push_item),
		.push      (push),
		.full      (full)
	);

	gtp_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.empty     (empty)
	);

	gtp_pack u_pack (
		.clk    (clk),
		.arst_n (arst_n),
		.filler (filler_q),
		.head   (head),
		.empty  (empty),
		.pop    (pop),
		.octets (octets)
	);

endmodule
